>>> rtl/apsp_pkg.sv
// ============================================================================
// apsp_pkg: shared types and constants for the all-pairs shortest path unit
// Request codes, internal command format, sequencer states and queue sizing.
// ============================================================================
package apsp_pkg;

    localparam int DEF_NUM_VERTICES = 8;
    localparam int DEF_DIST_WIDTH   = 24;

    localparam int VERTEX_WIDTH = 3;
    localparam int WEIGHT_WIDTH = 16;

    // Command queue between the front and the back part.
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef enum logic [1:0] {
        REQ_ADD_EDGE = 2'd0,
        REQ_CLOSURE  = 2'd1,
        REQ_READ     = 2'd2,
        REQ_CLEAR    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        OP_EDGE    = 2'd0,
        OP_CLOSURE = 2'd1,
        OP_READ    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [VERTEX_WIDTH-1:0] row;
        logic [VERTEX_WIDTH-1:0] col;
        logic [WEIGHT_WIDTH-1:0] weight;
        logic                    in_range;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EDGE,
        BK_EDGE2,
        BK_READ,
        BK_ROW,
        BK_SWEEP,
        BK_DRAIN
    } bk_state_t;

endpackage

>>> rtl/apsp_front.sv
// ============================================================================
// apsp_front: request intake and classification
// Takes input transfers, checks the vertex range and queues a command.
// ============================================================================
module apsp_front #(
    parameter int NUM_VERTICES = apsp_pkg::DEF_NUM_VERTICES
) (
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [apsp_pkg::VERTEX_WIDTH-1:0] from_vertex,
    input  logic [apsp_pkg::VERTEX_WIDTH-1:0] to_vertex,
    input  logic [apsp_pkg::WEIGHT_WIDTH-1:0] edge_weight,
    input  logic                              init_done,
    input  logic                              queue_full,
    output logic                              push,
    output apsp_pkg::cmd_t                    push_cmd
);
    import apsp_pkg::*;

    logic accept;
    logic in_range;

    assign in_stall = !init_done || queue_full;
    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(from_vertex) < NUM_VERTICES) && (32'(to_vertex) < NUM_VERTICES);

    always_comb
    begin
        push_cmd.row      = from_vertex;
        push_cmd.col      = to_vertex;
        push_cmd.weight   = edge_weight;
        push_cmd.in_range = in_range;
        push              = accept;
        case (req_type)
            REQ_ADD_EDGE:
            begin
                push_cmd.op = OP_EDGE;
                // An edge naming a vertex that is not stored changes nothing.
                push        = accept && in_range;
            end
            REQ_CLOSURE: push_cmd.op = OP_CLOSURE;
            REQ_READ:    push_cmd.op = OP_READ;
            REQ_CLEAR:   push_cmd.op = OP_CLEAR;
            default:     push_cmd.op = OP_CLEAR;
        endcase
    end

endmodule

>>> rtl/apsp_queue.sv
// ============================================================================
// apsp_queue: command queue
// Small first-in first-out buffer between the front and the back part.
// ============================================================================
module apsp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  apsp_pkg::cmd_t din,
    input  logic           pop,
    output apsp_pkg::cmd_t dout,
    output logic           full,
    output logic           empty
);
    import apsp_pkg::*;

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> rtl/apsp_back.sv
// ============================================================================
// apsp_back: matrix store and relaxation sequencer
// Holds the distance matrix in a memory and carries out queued commands.
// ============================================================================
module apsp_back #(
    parameter int NUM_VERTICES = apsp_pkg::DEF_NUM_VERTICES,
    parameter int DIST_WIDTH   = apsp_pkg::DEF_DIST_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  apsp_pkg::cmd_t          cmd,
    input  logic                    cmd_empty,
    output logic                    cmd_pop,
    output logic                    init_done,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [DIST_WIDTH:0] distance
);
    import apsp_pkg::*;

    localparam int VW    = $clog2(NUM_VERTICES);
    localparam int DEPTH = NUM_VERTICES * NUM_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = (DIST_WIDTH > WEIGHT_WIDTH) ? DIST_WIDTH : WEIGHT_WIDTH;
    localparam logic [DIST_WIDTH-1:0] UNREACH  = {DIST_WIDTH{1'b1}};
    localparam logic [VW-1:0]         LAST_V   = VW'(NUM_VERTICES - 1);

    function automatic logic [AW-1:0] entry_addr(logic [VW-1:0] r, logic [VW-1:0] c);
        return AW'(r) * AW'(NUM_VERTICES) + AW'(c);
    endfunction

    bk_state_t state_reg, state_next;

    logic [VW-1:0] i_reg, i_next;
    logic [VW-1:0] j_reg, j_next;
    logic [VW-1:0] k_reg, k_next;
    logic          drain_reg, drain_next;
    logic          init_done_reg;

    logic [VW-1:0]         cur_row_reg;
    logic [VW-1:0]         cur_col_reg;
    logic [DIST_WIDTH-1:0] cur_w_reg;
    logic                  cur_ok_reg;
    logic [DIST_WIDTH-1:0] q_val_reg;
    logic [DIST_WIDTH-1:0] dik_reg;

    logic                  s1_valid_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic                  s2_valid_reg;
    logic [AW-1:0]         s2_addr_reg;
    logic [DIST_WIDTH-1:0] s2_via_reg;
    logic [DIST_WIDTH-1:0] s2_cur_reg;

    logic [DIST_WIDTH-1:0] mem [DEPTH];
    logic [DIST_WIDTH-1:0] rd_a_reg;
    logic [DIST_WIDTH-1:0] rd_b_reg;

    logic                  out_valid_reg;
    logic [DIST_WIDTH:0]   dist_reg;

    logic [AW-1:0]         addr_a;
    logic [AW-1:0]         addr_b;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DIST_WIDTH-1:0] wdata;
    logic                  issue;
    logic                  out_free;

    logic [WW-1:0]         w_wide;
    logic [DIST_WIDTH-1:0] w_sat;
    logic [DIST_WIDTH:0]   via_sum;
    logic [DIST_WIDTH-1:0] via_sat;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;
    assign init_done = init_done_reg;

    // Weights at or above the unreachable code add no edge.
    assign w_wide = WW'(cmd.weight);
    assign w_sat  = (w_wide >= WW'(UNREACH)) ? UNREACH : DIST_WIDTH'(w_wide);

    // Saturating path length through the current intermediate vertex.
    assign via_sum = {1'b0, dik_reg} + {1'b0, rd_b_reg};
    assign via_sat = (via_sum >= {1'b0, UNREACH}) ? UNREACH : via_sum[DIST_WIDTH-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (i_reg == LAST_V && j_reg == LAST_V)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    case (cmd.op)
                        OP_EDGE:    state_next = BK_EDGE;
                        OP_CLOSURE: state_next = BK_ROW;
                        OP_READ:    state_next = out_free ? BK_READ : BK_IDLE;
                        OP_CLEAR:   state_next = BK_CLEAR;
                        default:    state_next = BK_IDLE;
                    endcase
                end
            end
            BK_EDGE:  state_next = BK_EDGE2;
            BK_EDGE2: state_next = BK_IDLE;
            BK_READ:  state_next = BK_IDLE;
            BK_ROW:   state_next = BK_SWEEP;
            BK_SWEEP:
            begin
                if (j_reg == LAST_V)
                begin
                    state_next = (i_reg == LAST_V) ? BK_DRAIN : BK_ROW;
                end
            end
            BK_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = (k_reg == LAST_V) ? BK_IDLE : BK_ROW;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs, memory control and counters.
    always_comb
    begin
        cmd_pop    = 1'b0;
        addr_a     = entry_addr(i_reg, j_reg);
        addr_b     = entry_addr(k_reg, j_reg);
        we         = 1'b0;
        waddr      = entry_addr(i_reg, j_reg);
        wdata      = UNREACH;
        issue      = 1'b0;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        drain_next = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                we    = 1'b1;
                wdata = (i_reg == j_reg) ? '0 : UNREACH;
                if (j_reg == LAST_V)
                begin
                    j_next = '0;
                    i_next = (i_reg == LAST_V) ? '0 : i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    addr_a = entry_addr(VW'(cmd.row), VW'(cmd.col));
                    addr_b = entry_addr(VW'(cmd.col), VW'(cmd.row));
                    case (cmd.op)
                        OP_READ: cmd_pop = out_free;
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            BK_EDGE:
            begin
                we    = 1'b1;
                waddr = entry_addr(cur_row_reg, cur_col_reg);
                wdata = (cur_w_reg < rd_a_reg) ? cur_w_reg : rd_a_reg;
            end
            BK_EDGE2:
            begin
                we    = 1'b1;
                waddr = entry_addr(cur_col_reg, cur_row_reg);
                wdata = q_val_reg;
            end
            BK_ROW:
            begin
                addr_a = entry_addr(i_reg, k_reg);
            end
            BK_SWEEP:
            begin
                issue = 1'b1;
                if (j_reg == LAST_V)
                begin
                    j_next = '0;
                    i_next = (i_reg == LAST_V) ? '0 : i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            BK_DRAIN:
            begin
                drain_next = !drain_reg;
                if (drain_reg)
                begin
                    k_next = (k_reg == LAST_V) ? '0 : k_reg + 1'b1;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        // Relaxation write-back; only in flight while the closure runs.
        if (s2_valid_reg && (s2_via_reg < s2_cur_reg))
        begin
            we    = 1'b1;
            waddr = s2_addr_reg;
            wdata = s2_via_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            drain_reg     <= 1'b0;
            init_done_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            drain_reg    <= drain_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (state_reg == BK_CLEAR && state_next == BK_IDLE)
            begin
                init_done_reg <= 1'b1;
            end
            if (state_reg == BK_READ)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_row_reg <= VW'(cmd.row);
            cur_col_reg <= VW'(cmd.col);
            cur_w_reg   <= w_sat;
            cur_ok_reg  <= cmd.in_range;
        end
        if (state_reg == BK_EDGE)
        begin
            q_val_reg <= (cur_w_reg < rd_b_reg) ? cur_w_reg : rd_b_reg;
        end
        if (state_reg == BK_SWEEP && j_reg == '0)
        begin
            dik_reg <= rd_a_reg;
        end
        if (state_reg == BK_READ)
        begin
            if (cur_ok_reg && rd_a_reg != UNREACH)
            begin
                dist_reg <= {1'b0, rd_a_reg};
            end
            else
            begin
                dist_reg <= '1;
            end
        end
        s1_addr_reg <= entry_addr(i_reg, j_reg);
        s2_addr_reg <= s1_addr_reg;
        s2_via_reg  <= via_sat;
        s2_cur_reg  <= rd_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

endmodule

>>> rtl/all_pairs_shortest_path_unit.sv
// ============================================================================
// all_pairs_shortest_path_unit: Floyd-Warshall distance matrix engine
// Keeps a vertex-by-vertex distance matrix and answers distance reads.
// ============================================================================
// Requests arrive on the input channel (in_valid / in_stall); a transfer is
// one request: add edge, run closure, read entry or clear matrix. Only a read
// produces a transfer on the output channel (out_valid / out_stall), carrying
// the stored distance, or -1 when the entry is unreachable or out of range.
// A front stage classifies each request and puts it into a four-entry command
// queue, so new requests are taken while the matrix engine is still busy.
// Engine steps, K = NUM_VERTICES:
//   read:    the entry is fetched, then the result is registered on the output;
//   edge:    read both symmetric entries, write each back;
//   clear:   all K*K entries, one matrix entry written per cycle;
//   closure: one relaxation per cycle, bounded by the single write port of
//            the matrix memory; each row first fetches its pivot entry and
//            each intermediate vertex then drains the relaxation pipeline.
// After reset the engine writes all K*K entries of the reset matrix in a pass and
// in_stall stays high until that pass ends. A stalled result holds on the
// output; a read waiting behind it stays at the head of the queue, together
// with everything after it, and requests keep coming in until the queue fills.
// ============================================================================
module all_pairs_shortest_path_unit #(
    parameter int NUM_VERTICES = apsp_pkg::DEF_NUM_VERTICES,
    parameter int DIST_WIDTH   = apsp_pkg::DEF_DIST_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [apsp_pkg::VERTEX_WIDTH-1:0] from_vertex,
    input  logic [apsp_pkg::VERTEX_WIDTH-1:0] to_vertex,
    input  logic [apsp_pkg::WEIGHT_WIDTH-1:0] edge_weight,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [DIST_WIDTH:0]        distance
);
    import apsp_pkg::*;

    logic init_done;
    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // The front only classifies; all matrix work happens in the back part.
    apsp_front #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .from_vertex (from_vertex),
        .to_vertex   (to_vertex),
        .edge_weight (edge_weight),
        .init_done   (init_done),
        .queue_full  (queue_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    apsp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .pop   (pop),
        .dout  (head_cmd),
        .full  (queue_full),
        .empty (queue_empty)
    );

    // The back part pops a command only when it can start it, so reads wait
    // in the queue while the output register is still held by a stall.
    apsp_back #(
        .NUM_VERTICES (NUM_VERTICES),
        .DIST_WIDTH   (DIST_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (queue_empty),
        .cmd_pop   (pop),
        .init_done (init_done),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .distance  (distance)
    );

endmodule
